### hdl/bss_pkg.sv
// Shared types and constants for the byte stuffing packet segmenter.
// No dependencies; imported by bss_framer, bss_emitter and the top level.
`default_nettype none

package bss_pkg;

    // Data bytes that must be followed by a stuffing byte.
    localparam logic [7:0] ESC_BYTE_A = 8'h81;
    localparam logic [7:0] ESC_BYTE_B = 8'h88;
    localparam logic [7:0] STUFF_BYTE = 8'hff;

    localparam int SEQ_W   = 5;
    localparam int LEN_W   = 7;
    localparam int BYTE_W  = 8;
    // The most results that one input byte can cause.
    localparam int RUN_MAX = 4;
    localparam int RUN_IDX_W = $clog2(RUN_MAX);

    // Result kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [SEQ_W-1:0]  packet_seq;
        logic [LEN_W-1:0]  packet_length;
        logic              last_of_run;
    } bss_res_t;

    typedef bss_res_t [RUN_MAX-1:0] bss_run_t;

endpackage

`default_nettype wire

### hdl/byte_stuffing_packet_segmenter.sv
// Top level of the byte stuffing packet segmenter.
// Depends on bss_pkg, bss_framer and bss_emitter.
//
// Usage: raw data bytes enter on the s_ stream, one per transfer, with
// s_tlast marking the byte that ends a segment. Each byte produces one to
// four result transfers on the m_ stream: payload bytes (m_tuser = 0) and
// packet-closed markers (m_tuser = 1). A data byte of 0x81 or 0x88 is
// followed by a 0xff stuffing byte. A packet closes when its payload of
// PACKET_BYTES-4 bytes is full, before an escaped byte that would land on
// the last free slot, and at the end of a segment if it holds any bytes.
// Every closed packet uses one 5-bit sequence number, wrapping at 31.
// m_tlast is high on the last result caused by an input byte.
//
// The results of an input transfer pass through the run buffer and then
// the output register. A byte occupies the block until its last result
// has moved on, so plain bytes flow at one per cycle while the receiver
// keeps up; an escape and each close add a result. The limit is the single
// output register, which moves one result per cycle unless the receiver stalls.
// When the receiver stalls, the output register holds its result and the
// pending run is kept, while s_tready drops once the run buffer is
// occupied. Reset clears the fill count, the sequence number and all valid
// flags; no output is pending.
`default_nettype none

module byte_stuffing_packet_segmenter #(
    parameter int PACKET_BYTES = 68
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_segment
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] payload_byte, [12:8] packet_seq,
                                        // [19:13] packet_length, [23:20] zero
    output logic             m_tuser,   // kind
    output logic             m_tlast    // last_of_run
);
    import bss_pkg::*;

    localparam int CAP    = PACKET_BYTES - 4;
    // The fill count must hold CAP transiently.
    localparam int FILL_W = $clog2(CAP + 2);

    logic     accept;
    bss_run_t run;
    bss_res_t res;

    assign accept = s_tvalid && s_tready;

    bss_framer #(
        .CAP    (CAP),
        .FILL_W (FILL_W)
    ) u_framer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_tdata),
        .end_of_segment (s_tlast),
        .run            (run)
    );

    bss_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .run_in    (run),
        .can_load  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {4'b0000, res.packet_length, res.packet_seq, res.payload_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_of_run;

endmodule

`default_nettype wire

### hdl/bss_framer.sv
// Packet framing state (fill count, sequence number) and the decode of one
// input byte into its ordered list of results. Depends on bss_pkg.
`default_nettype none

module bss_framer #(
    parameter int CAP    = 64,
    parameter int FILL_W = 7
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [7:0]          data_byte,
    input  wire logic                end_of_segment,
    output bss_pkg::bss_run_t        run
);
    import bss_pkg::*;

    localparam int LW = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;

    logic              esc;
    logic              pre_close;
    logic              post_close;
    logic [FILL_W-1:0] fill_a;
    logic [FILL_W-1:0] fill_b;
    logic [SEQ_W-1:0]  seq_a;
    logic [LW-1:0]     pre_len_wide;
    logic [LW-1:0]     post_len_wide;

    assign esc       = (data_byte == ESC_BYTE_A) || (data_byte == ESC_BYTE_B);
    // An escaped byte never straddles two packets: close early instead.
    assign pre_close = esc && (fill_reg == FILL_W'(CAP - 1));
    assign fill_a    = pre_close ? '0 : fill_reg;
    assign seq_a     = pre_close ? SEQ_W'(seq_reg + 1'b1) : seq_reg;
    assign fill_b    = fill_a + (esc ? FILL_W'(2) : FILL_W'(1));
    // After the byte the packet is never empty, so end of segment closes it.
    assign post_close = (fill_b >= FILL_W'(CAP)) || end_of_segment;

    assign pre_len_wide  = LW'(fill_reg);
    assign post_len_wide = LW'(fill_b);

    assign fill_next = post_close ? '0 : fill_b;
    assign seq_next  = post_close ? SEQ_W'(seq_a + 1'b1) : seq_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            seq_reg  <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
            seq_reg  <= seq_next;
        end
    end

    // Pack the results in order; p ends on the final one.
    always_comb begin
        logic [RUN_IDX_W-1:0] p;
        run = '0;
        p   = '0;
        if (pre_close) begin
            run[0].kind          = KIND_CLOSE;
            run[0].packet_seq    = seq_reg;
            run[0].packet_length = pre_len_wide[LEN_W-1:0];
            p = RUN_IDX_W'(1);
        end
        run[p].kind         = KIND_BYTE;
        run[p].payload_byte = data_byte;
        run[p].packet_seq   = seq_a;
        if (esc) begin
            p = p + 1'b1;
            run[p].kind         = KIND_BYTE;
            run[p].payload_byte = STUFF_BYTE;
            run[p].packet_seq   = seq_a;
        end
        if (post_close) begin
            p = p + 1'b1;
            run[p].kind          = KIND_CLOSE;
            run[p].packet_seq    = seq_a;
            run[p].packet_length = post_len_wide[LEN_W-1:0];
        end
        run[p].last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

### hdl/bss_emitter.sv
// Holds the results of one input byte and hands them out one per cycle
// while not stalled, through a registered output stage. Depends on bss_pkg.
`default_nettype none

module bss_emitter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  bss_pkg::bss_run_t      run_in,
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bss_pkg::bss_res_t      out_res
);
    import bss_pkg::*;

    bss_run_t             run_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 run_valid_reg;
    bss_res_t             out_reg;
    logic                 out_valid_reg;

    logic out_load;
    logic run_done;

    assign out_load = run_valid_reg && (!out_valid_reg || out_ready);
    assign run_done = out_load && run_reg[idx_reg].last_of_run;
    assign can_load = !run_valid_reg || run_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                run_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (run_done) begin
                run_valid_reg <= 1'b0;
            end else if (out_load) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run_in;
        end
        if (out_load) begin
            out_reg <= run_reg[idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for byte_stuffing_packet_segmenter.
// Depends on bss_pkg and the RTL; byte transfers come from a queue, and a
// built-in packetizer predicts the payload and close-marker results.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int PACKET_BYTES = 68;
    localparam int PAYLOAD_CAP  = PACKET_BYTES - 4;
    localparam int RANDOM_BYTES = 250;
    // Worst case is roughly 300 bytes, 4 results each, every result held by
    // the longest stall plus the longest gap per byte. Allow several times that.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_segment;
    } raw_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    raw_byte_t raw_bytes_q[$];      // bytes still waiting to be sent
    bss_res_t  pending_results[$];  // predicted results, oldest first

    // Predictor state: the open packet's fill and sequence number.
    int        open_fill = 0;
    logic [4:0] open_seq = '0;

    // Shadow fill used only while building the stimulus, so that segments
    // can be steered onto the last free slot and onto a full payload.
    int        gen_fill = 0;

    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        src_gap = 0;
    int        src_calm = 0;
    int        sink_stall = 0;
    int        sink_calm = 0;

    byte_stuffing_packet_segmenter #(
        .PACKET_BYTES(PACKET_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic is_escape(logic [7:0] b);
        return (b == ESC_BYTE_A) || (b == ESC_BYTE_B);
    endfunction

    // Fill after one byte, before any close caused by a full payload.
    function automatic int next_fill(int f, logic [7:0] b);
        if (is_escape(b)) begin
            return (f == PAYLOAD_CAP - 1) ? 2 : f + 2;
        end
        return f + 1;
    endfunction

    function automatic void add_item(logic [7:0] b, logic eos);
        raw_byte_t it;
        int nf;
        it.data_byte      = b;
        it.end_of_segment = eos;
        raw_bytes_q.push_back(it);
        nf = next_fill(gen_fill, b);
        gen_fill = (nf >= PAYLOAD_CAP || eos) ? 0 : nf;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_result(logic kind, logic [7:0] b, logic [6:0] len);
        bss_res_t r;
        r.kind          = kind;
        r.payload_byte  = b;
        r.packet_seq    = open_seq;
        r.packet_length = len;
        r.last_of_run   = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void close_open_packet();
        push_result(KIND_CLOSE, 8'h00, open_fill[6:0]);
        open_seq  = open_seq + 5'd1;
        open_fill = 0;
    endfunction

    // Works out every result that one accepted byte causes.
    function automatic void packetize_byte(raw_byte_t it);
        bss_res_t tail;
        if (is_escape(it.data_byte)) begin
            // An escape pair never straddles two packets.
            if (open_fill == PAYLOAD_CAP - 1) close_open_packet();
            push_result(KIND_BYTE, it.data_byte, 7'd0);
            push_result(KIND_BYTE, STUFF_BYTE, 7'd0);
            open_fill += 2;
        end else begin
            push_result(KIND_BYTE, it.data_byte, 7'd0);
            open_fill += 1;
        end
        if (open_fill >= PAYLOAD_CAP) close_open_packet();
        // An end of segment on an empty packet adds no marker.
        if (it.end_of_segment && open_fill != 0) close_open_packet();
        tail = pending_results.pop_back();
        tail.last_of_run = 1'b1;
        pending_results.push_back(tail);
    endfunction

    // Source side: a new transfer is offered once the previous one has
    // completed and its random gap has run out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap != 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (raw_bytes_q.size() != 0) begin
                raw_byte_t it;
                it = raw_bytes_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.data_byte;
                s_tlast  <= it.end_of_segment;
                if (src_calm != 0) begin
                    src_calm <= src_calm - 1;
                    src_gap  <= 0;
                end else if ($urandom_range(0, 99) < 4) begin
                    src_calm <= $urandom_range(20, 60);
                    src_gap  <= 0;
                end else begin
                    src_gap  <= pause_len();
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stalls, with occasional stretches of full speed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall != 0) begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if (sink_calm != 0) begin
                sink_calm <= sink_calm - 1;
            end else if ($urandom_range(0, 99) < 3) begin
                sink_calm <= $urandom_range(30, 80);
            end else if ($urandom_range(0, 99) < 20) begin
                sink_stall <= pause_len();
            end
        end
    end

    // Monitor: predict on each accepted byte, then check each accepted result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                raw_byte_t it;
                it.data_byte      = s_tdata;
                it.end_of_segment = s_tlast;
                packetize_byte(it);
            end
            if (m_tvalid && m_tready) begin
                bss_res_t want;
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer: tdata %0h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[7:0] !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[12:8] !== want.packet_seq) begin
                        $error("packet_seq: expected %0d, got %0d",
                               want.packet_seq, m_tdata[12:8]);
                        mismatch_count++;
                    end
                    if (m_tdata[19:13] !== want.packet_length) begin
                        $error("packet_length: expected %0d, got %0d",
                               want.packet_length, m_tdata[19:13]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int seg_len;
        int idx;
        int nf;
        int total;
        logic [7:0] b;
        logic eos;

        // Directed: byte extremes, both escape bytes, escapes back to back,
        // and many one-byte segments, each of which closes its own packet.
        add_item(8'h00, 1'b1);
        add_item(8'hff, 1'b1);
        add_item(ESC_BYTE_A, 1'b1);
        add_item(ESC_BYTE_B, 1'b1);
        add_item(8'h80, 1'b1);
        add_item(8'h89, 1'b1);
        add_item(8'h7f, 1'b1);
        add_item(8'h01, 1'b1);
        add_item(ESC_BYTE_A, 1'b0);
        add_item(ESC_BYTE_B, 1'b1);
        add_item(8'haa, 1'b0);
        add_item(8'h55, 1'b1);
        for (idx = 0; idx < 10; idx++) begin
            add_item(8'($urandom_range(0, 255)), 1'b1);
        end

        // Random segments: mostly short, some long enough to fill packets.
        // At the last free slot an escape byte is favored, and a byte that
        // fills a packet often ends its segment as well.
        total = raw_bytes_q.size() + RANDOM_BYTES;
        while (raw_bytes_q.size() < total) begin
            seg_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                                   : $urandom_range(40, 140);
            for (idx = 0; idx < seg_len && raw_bytes_q.size() < total; idx++) begin
                if ((gen_fill == PAYLOAD_CAP - 1 && $urandom_range(0, 99) < 60) ||
                    $urandom_range(0, 99) < 12) begin
                    b = $urandom_range(0, 1) ? ESC_BYTE_A : ESC_BYTE_B;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                nf  = next_fill(gen_fill, b);
                eos = (idx == seg_len - 1) ||
                      (nf >= PAYLOAD_CAP && $urandom_range(0, 99) < 40);
                add_item(b, eos);
                if (eos) break;
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample at the falling edge, after all rising-edge activity settled.
        while (raw_bytes_q.size() != 0 || s_tvalid || pending_results.size() != 0) begin
            @(negedge aclk);
        end
        // Leave room for any stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
